// ----- design/wrpm_pkg.sv -----
`timescale 1ns / 1ps

package wrpm_pkg;

  // Converter code width and default fraction bits of the root
  localparam int ADC_BITS       = 10;
  localparam int SQRT_FRAC_BITS = 8;

  // Accumulator and counter widths
  localparam int SUM_W   = 37;
  localparam int CNT_W   = 16;
  localparam int SQ_W    = 2 * ADC_BITS;

  // Configuration register widths
  localparam int GATE_W    = 10;
  localparam int WLEN_W    = 16;
  localparam int VGAIN_W   = 24;
  localparam int COFF_W    = 10;
  localparam int CGAIN_W   = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration reset values
  localparam logic [GATE_W-1:0]  GATE_RST  = GATE_W'(200);
  localparam logic [WLEN_W-1:0]  WLEN_RST  = WLEN_W'(1000);
  localparam logic [VGAIN_W-1:0] VGAIN_RST = VGAIN_W'(496472);
  localparam logic [COFF_W-1:0]  COFF_RST  = COFF_W'(512);
  localparam logic [CGAIN_W-1:0] CGAIN_RST = CGAIN_W'(22624);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_GAIN      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_OFFSET = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN   = CFG_IDX_W'(4);

  // Input word
  typedef struct packed {
    logic [ADC_BITS-1:0] voltage_sample;
    logic [ADC_BITS-1:0] current_sample;
  } meter_in_t;

  // Result word
  typedef struct packed {
    logic [15:0]         rms_volts_x10;
    logic signed [15:0]  amps_x10;
    logic [ADC_BITS-1:0] peak_code;
    logic [CNT_W-1:0]    gated_count;
    logic [CNT_W-1:0]    rise_count;
    logic                empty_window;
  } meter_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic accum;
    logic div_step;
    logic root_load;
    logic root_step;
    logic mul;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic close;
    logic step_done;
    logic out_free;
  } sts_t;

endpackage

// ----- design/wrpm_ctrl.sv -----
`timescale 1ns / 1ps

module wrpm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  wrpm_pkg::sts_t sts,
  output wrpm_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_RLD,
    S_ROOT,
    S_MUL,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = sts.close ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_done) state_nxt = S_RLD;
      end
      S_RLD: begin
        cmd.root_load = 1'b1;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.step_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

// ----- design/wrpm_dp.sv -----
`timescale 1ns / 1ps

module wrpm_dp #(
  parameter int SQRT_FRAC_BITS = wrpm_pkg::SQRT_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wrpm_pkg::meter_in_t                 in_data,
  input  logic                                cfg_we,
  input  logic [wrpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wrpm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wrpm_pkg::cmd_t                      cmd,
  output wrpm_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wrpm_pkg::meter_out_t                out_data
);

  localparam int ADC_W  = wrpm_pkg::ADC_BITS;
  localparam int SUM_W  = wrpm_pkg::SUM_W;
  localparam int CNT_W  = wrpm_pkg::CNT_W;
  localparam int SQ_W   = wrpm_pkg::SQ_W;
  localparam int DIV_W  = SUM_W + 2 * SQRT_FRAC_BITS;
  localparam int ROOT_W = (DIV_W + 1) / 2;
  localparam int RX_W   = 2 * ROOT_W;
  localparam int SREM_W = ROOT_W + 2;
  localparam int PV_W   = ROOT_W + wrpm_pkg::VGAIN_W;
  localparam int PV_SH  = 16 + SQRT_FRAC_BITS;
  localparam int PA_W   = ADC_W + 1 + wrpm_pkg::CGAIN_W + 1;
  localparam int STEP_W = $clog2(DIV_W);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration registers
  logic [wrpm_pkg::GATE_W-1:0]  gate_r;
  logic [wrpm_pkg::WLEN_W-1:0]  wlen_r;
  logic [wrpm_pkg::VGAIN_W-1:0] vgain_r;
  logic [wrpm_pkg::COFF_W-1:0]  coff_r;
  logic [wrpm_pkg::CGAIN_W-1:0] cgain_r;

  // Captured sample
  logic [ADC_W-1:0] v_r, c_r;
  logic [SQ_W-1:0]  sq_r;

  // Window accumulators
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] scnt_r, scnt_nxt;
  logic [ADC_W-1:0] peak_r, peak_nxt;
  logic [CNT_W-1:0] rcnt_r, rcnt_nxt;
  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic [SUM_W:0]   sum_add;
  logic [wrpm_pkg::WLEN_W-1:0] len;
  logic gated, rise;

  // Closed window snapshot
  logic [ADC_W-1:0] res_peak_r;
  logic [CNT_W-1:0] res_scnt_r;
  logic [CNT_W-1:0] res_rcnt_r;

  // Divider, root and multiplier state
  logic [STEP_W-1:0] step_r;
  logic [DIV_W-1:0]  dq_r;
  logic [CNT_W-1:0]  rem_r, div_r;
  logic [CNT_W:0]    rem_sh, rem_dif;
  logic              div_ge;
  logic [RX_W-1:0]   rx_r;
  logic [ROOT_W-1:0] root_r;
  logic [SREM_W-1:0] srem_r, srem_sh, trial, srem_dif;
  logic              root_ge;
  logic [PV_W-1:0]   pv_r, pv_sh;
  logic signed [PA_W-1:0]  pa_r;
  logic signed [ADC_W:0]   adiff;
  logic [15:0]       rms_sat;

  // Output register
  logic                 out_valid_r;
  wrpm_pkg::meter_out_t out_data_r;

  // Accumulate one tick
  always_comb begin
    gated    = (v_r >= gate_r);
    sum_add  = {1'b0, sum_r} + (SUM_W + 1)'(sq_r);
    sum_nxt  = sum_r;
    scnt_nxt = scnt_r;
    if (gated) begin
      sum_nxt = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      if (scnt_r != CNT_MAX) scnt_nxt = scnt_r + CNT_W'(1);
    end
    rise     = (c_r >= peak_r);
    peak_nxt = rise ? c_r : peak_r;
    rcnt_nxt = (rise && rcnt_r != CNT_MAX) ? rcnt_r + CNT_W'(1) : rcnt_r;
    tick_nxt = (tick_r != CNT_MAX) ? tick_r + CNT_W'(1) : tick_r;
    // A zero length closes every tick
    len      = (wlen_r == '0) ? wrpm_pkg::WLEN_W'(1) : wlen_r;
  end

  // Restoring divide and root steps
  always_comb begin
    rem_sh   = {rem_r, dq_r[DIV_W-1]};
    rem_dif  = rem_sh - {1'b0, div_r};
    div_ge   = (rem_sh >= {1'b0, div_r});
    srem_sh  = {srem_r[SREM_W-3:0], rx_r[RX_W-1:RX_W-2]};
    trial    = {root_r, 2'b01};
    srem_dif = srem_sh - trial;
    root_ge  = (srem_sh >= trial);
  end

  // Scale and saturate the result
  always_comb begin
    adiff   = $signed({1'b0, res_peak_r}) - $signed({1'b0, coff_r});
    pv_sh   = pv_r >> PV_SH;
    rms_sat = (|pv_sh[PV_W-1:16]) ? 16'hFFFF : pv_sh[15:0];
  end

  assign sts.close     = (tick_nxt >= len);
  assign sts.step_done = (step_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r  <= wrpm_pkg::GATE_RST;
      wlen_r  <= wrpm_pkg::WLEN_RST;
      vgain_r <= wrpm_pkg::VGAIN_RST;
      coff_r  <= wrpm_pkg::COFF_RST;
      cgain_r <= wrpm_pkg::CGAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wrpm_pkg::REG_GATE_THRESHOLD: gate_r  <= cfg_data[wrpm_pkg::GATE_W-1:0];
        wrpm_pkg::REG_WINDOW_LEN:     wlen_r  <= cfg_data[wrpm_pkg::WLEN_W-1:0];
        wrpm_pkg::REG_VOLT_GAIN:      vgain_r <= cfg_data[wrpm_pkg::VGAIN_W-1:0];
        wrpm_pkg::REG_CURRENT_OFFSET: coff_r  <= cfg_data[wrpm_pkg::COFF_W-1:0];
        wrpm_pkg::REG_CURRENT_GAIN:   cgain_r <= cfg_data[wrpm_pkg::CGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the word and square the voltage
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v_r  <= in_data.voltage_sample;
      c_r  <= in_data.current_sample;
      sq_r <= SQ_W'(in_data.voltage_sample) * SQ_W'(in_data.voltage_sample);
    end
  end

  // Advance accumulators, clear them at window close
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      scnt_r <= '0;
      peak_r <= '0;
      rcnt_r <= '0;
      tick_r <= '0;
    end else if (cmd.accum) begin
      if (sts.close) begin
        sum_r  <= '0;
        scnt_r <= '0;
        peak_r <= '0;
        rcnt_r <= '0;
        tick_r <= '0;
      end else begin
        sum_r  <= sum_nxt;
        scnt_r <= scnt_nxt;
        peak_r <= peak_nxt;
        rcnt_r <= rcnt_nxt;
        tick_r <= tick_nxt;
      end
    end
  end

  // Snapshot, divide, root and multiply
  always_ff @(posedge clk) begin
    if (cmd.accum && sts.close) begin
      res_peak_r <= peak_nxt;
      res_scnt_r <= scnt_nxt;
      res_rcnt_r <= rcnt_nxt;
      dq_r       <= DIV_W'(sum_nxt) << (2 * SQRT_FRAC_BITS);
      div_r      <= scnt_nxt;
      rem_r      <= '0;
      step_r     <= STEP_W'(DIV_W - 1);
    end
    if (cmd.div_step) begin
      rem_r  <= div_ge ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dq_r   <= {dq_r[DIV_W-2:0], div_ge};
      step_r <= step_r - STEP_W'(1);
    end
    if (cmd.root_load) begin
      rx_r   <= RX_W'(dq_r);
      srem_r <= '0;
      root_r <= '0;
      step_r <= STEP_W'(ROOT_W - 1);
    end
    if (cmd.root_step) begin
      srem_r <= root_ge ? srem_dif : srem_sh;
      root_r <= {root_r[ROOT_W-2:0], root_ge};
      rx_r   <= rx_r << 2;
      step_r <= step_r - STEP_W'(1);
    end
    if (cmd.mul) begin
      pv_r <= PV_W'(root_r) * PV_W'(vgain_r);
      pa_r <= PA_W'(adiff) * $signed({1'b0, cgain_r});
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.rms_volts_x10 <= (res_scnt_r == '0) ? 16'h0000 : rms_sat;
      // Arithmetic shift floors; the product range keeps it within 16 bits
      out_data_r.amps_x10      <= pa_r[PA_W-1:16];
      out_data_r.peak_code     <= res_peak_r;
      out_data_r.gated_count   <= res_scnt_r;
      out_data_r.rise_count    <= res_rcnt_r;
      out_data_r.empty_window  <= (res_scnt_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/windowed_rms_peak_meter_top.sv -----
`timescale 1ns / 1ps

// Windowed RMS voltage and peak current meter. Each input word is one tick with
// a voltage and a current code; once window_len ticks have gone by, one result
// word carries the RMS voltage and scaled peak current of that window and the
// accumulators start over. An ordinary tick is accepted, then accumulated. The
// closing tick then runs the divider, loads and runs the square root and the
// multiply, and waits until the output register is free, before the next word
// is accepted. The divider is DIV_W = 37 + 2*SQRT_FRAC_BITS bits wide and the
// root ROOT_W = (DIV_W+1)/2 bits. Both are one-bit-per-cycle restoring
// units and share one step counter. A result waits in an output register, so
// input words keep flowing while it is stalled; only a second window close
// waits for that register to drain. Configuration writes are always ready
// and must be made while the meter is idle.
module windowed_rms_peak_meter_top #(
  parameter int SQRT_FRAC_BITS = wrpm_pkg::SQRT_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wrpm_pkg::meter_in_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wrpm_pkg::meter_out_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wrpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrpm_pkg::CFG_DATA_W-1:0] cfg_data
);

  wrpm_pkg::cmd_t cmd;
  wrpm_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  wrpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wrpm_dp #(
    .SQRT_FRAC_BITS (SQRT_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // An accepted word is accumulated in the next cycle
  a_accept_accum: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> cmd.accum)
    else $error("accepted word not accumulated");

  // A result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending word");

  // The shared divide and root unit runs only while input is held off
  a_steps_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.root_step || cmd.mul) |-> in_stall)
    else $error("datapath step while input open");
`endif

endmodule
